// ===== design/obb_pkg.sv =====
package obb_pkg;

    localparam int CW     = 21;
    localparam int FRAC   = 19;
    localparam int IN_W   = 63;
    localparam int NCELL  = 15;
    localparam int NFACE  = 3;
    localparam int LW     = (2 * CW + 1 > CW + FRAC) ? 2 * CW + 1 : CW + FRAC;
    localparam int DW     = LW + CW + 2;
    localparam int DL     = DW / 2;
    localparam int DH     = DW - DL;
    localparam int RW     = DW + CW + 3;
    localparam int TW     = LW + CW + 4;
    localparam int CMPW   = RW + TW + FRAC;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } t_vec;

    typedef struct packed {
        logic signed [LW-1:0] z;
        logic signed [LW-1:0] y;
        logic signed [LW-1:0] x;
    } t_lvec;

    typedef struct packed {
        t_vec       ca;
        t_vec       ea;
        t_vec [2:0] axa;
        t_vec       cb;
        t_vec       eb;
        t_vec [2:0] axb;
    } t_item;

    typedef enum logic [1:0] {
        AX_FACE_A,
        AX_FACE_B,
        AX_CROSS
    } t_axis_kind;

    typedef struct packed {
        t_axis_kind  kind;
        logic [1:0]  ia;
        logic [1:0]  ib;
    } t_axis_sel;

    function automatic t_lvec face_axis(t_vec a);
        t_lvec r;
        r.x = LW'(a.x) <<< FRAC;
        r.y = LW'(a.y) <<< FRAC;
        r.z = LW'(a.z) <<< FRAC;
        return r;
    endfunction

    function automatic t_lvec cross_prod(t_vec a, t_vec b);
        t_lvec r;
        r.x = LW'(a.y) * LW'(b.z) - LW'(a.z) * LW'(b.y);
        r.y = LW'(a.z) * LW'(b.x) - LW'(a.x) * LW'(b.z);
        r.z = LW'(a.x) * LW'(b.y) - LW'(a.y) * LW'(b.x);
        return r;
    endfunction

    function automatic logic signed [DW-1:0] dot_ax(t_lvec l, t_vec v);
        logic signed [DW-1:0] s;
        s = DW'(l.x) * DW'(v.x) + DW'(l.y) * DW'(v.y) + DW'(l.z) * DW'(v.z);
        return s;
    endfunction

    function automatic logic signed [CW-1:0] comp(t_vec v, logic [1:0] k);
        logic signed [CW-1:0] c;
        case (k)
            2'd0:    c = v.x;
            2'd1:    c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

endpackage

// ===== design/obb_cell.sv =====
module obb_cell
    import obb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_axis_sel i_sel,
    input  logic      i_valid,
    input  t_item     i_item,
    input  logic      i_hit,
    output logic      o_valid,
    output t_item     o_item,
    output logic      o_hit
);

    logic [4:0]            r_v;
    logic [4:0]            r_hit;
    t_item                 r_item [5];
    t_lvec                 n_l, r_l;
    logic signed [DW-1:0]  n_d [6];
    logic signed [DW-1:0]  r_d [6];
    logic signed [TW-1:0]  n_t, r_t, r3_t, r4_t;
    logic [DL+CW-1:0]      n_lo [6];
    logic [DL+CW-1:0]      r_lo [6];
    logic [DH+CW-1:0]      n_hi [6];
    logic [DH+CW-1:0]      r_hi [6];
    logic [RW-1:0]         n_r, r_r;
    logic                  n_ok;

    // stage 1: candidate axis
    always_comb begin
        case (i_sel.kind)
            AX_FACE_A: n_l = face_axis(i_item.axa[i_sel.ia]);
            AX_FACE_B: n_l = face_axis(i_item.axb[i_sel.ib]);
            AX_CROSS:  n_l = cross_prod(i_item.axa[i_sel.ia], i_item.axb[i_sel.ib]);
            default:   n_l = '0;
        endcase
    end

    // stage 2: projections of box axes and center offset
    always_comb begin
        logic signed [CW:0] dx, dy, dz;
        dx = (CW+1)'(r_item[0].cb.x) - (CW+1)'(r_item[0].ca.x);
        dy = (CW+1)'(r_item[0].cb.y) - (CW+1)'(r_item[0].ca.y);
        dz = (CW+1)'(r_item[0].cb.z) - (CW+1)'(r_item[0].ca.z);
        for (int k = 0; k < NFACE; k++) begin
            n_d[k]         = dot_ax(r_l, r_item[0].axa[k]);
            n_d[NFACE + k] = dot_ax(r_l, r_item[0].axb[k]);
        end
        n_t = TW'(r_l.x) * TW'(dx) + TW'(r_l.y) * TW'(dy) + TW'(r_l.z) * TW'(dz);
    end

    // stage 3: |d| * |e|, split in two partial products
    always_comb begin
        logic [DW-1:0]        ad;
        logic signed [CW-1:0] e;
        logic [CW-1:0]        ae;
        for (int k = 0; k < 2 * NFACE; k++) begin
            ad = r_d[k][DW-1] ? DW'(-r_d[k]) : DW'(r_d[k]);
            e  = (k < NFACE) ? comp(r_item[1].ea, 2'(k)) : comp(r_item[1].eb, 2'(k - NFACE));
            ae = e[CW-1] ? CW'(-e) : CW'(e);
            n_lo[k] = (DL+CW)'(ad[DL-1:0]) * (DL+CW)'(ae);
            n_hi[k] = (DH+CW)'(ad[DW-1:DL]) * (DH+CW)'(ae);
        end
    end

    // stage 4: projected radius of both boxes
    always_comb begin
        n_r = '0;
        for (int k = 0; k < 2 * NFACE; k++) begin
            n_r = n_r + (RW'(r_hi[k]) << DL) + RW'(r_lo[k]);
        end
    end

    // stage 5: closed interval test |dist| <= radius
    always_comb begin
        logic signed [CMPW-1:0] x, rr;
        x    = CMPW'(r4_t) <<< FRAC;
        rr   = signed'(CMPW'(r_r));
        n_ok = (x <= rr) && (-x <= rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int s = 1; s < 5; s++) begin
                r_item[s] <= r_item[s-1];
            end
            r_hit <= {r_hit[3] & n_ok, r_hit[2:0], i_hit};
            r_l   <= n_l;
            r_d   <= n_d;
            r_t   <= n_t;
            r3_t  <= r_t;
            r4_t  <= r3_t;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_r   <= n_r;
        end
    end

    assign o_valid = r_v[4];
    assign o_item  = r_item[4];
    assign o_hit   = r_hit[4];

endmodule

// ===== design/obb_obb_sat_overlap_unit.sv =====
// Separating-axis overlap test of two oriented boxes. One box pair is taken
// per cycle; the verdict comes out of fifteen axis cells in a row,
// five register stages each, every cell testing one axis and passing the pair
// and the running hit flag to its neighbor. The whole row advances together,
// so a result not taken at the output holds the row and deasserts o_ready.
module obb_obb_sat_overlap_unit
    import obb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_first_center,
    input  logic [IN_W-1:0] i_first_extents,
    input  logic [IN_W-1:0] i_first_axis_x,
    input  logic [IN_W-1:0] i_first_axis_y,
    input  logic [IN_W-1:0] i_first_axis_z,
    input  logic [IN_W-1:0] i_second_center,
    input  logic [IN_W-1:0] i_second_extents,
    input  logic [IN_W-1:0] i_second_axis_x,
    input  logic [IN_W-1:0] i_second_axis_y,
    input  logic [IN_W-1:0] i_second_axis_z,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_boxes_intersect
);

    t_item     w_item [NCELL+1];
    logic      w_v    [NCELL+1];
    logic      w_hit  [NCELL+1];
    t_axis_sel w_sel  [NCELL];
    logic      w_en;

    assign w_en = !w_v[NCELL] || i_ready;

    always_comb begin
        w_item[0].ca     = t_vec'(i_first_center[3*CW-1:0]);
        w_item[0].ea     = t_vec'(i_first_extents[3*CW-1:0]);
        w_item[0].axa[0] = t_vec'(i_first_axis_x[3*CW-1:0]);
        w_item[0].axa[1] = t_vec'(i_first_axis_y[3*CW-1:0]);
        w_item[0].axa[2] = t_vec'(i_first_axis_z[3*CW-1:0]);
        w_item[0].cb     = t_vec'(i_second_center[3*CW-1:0]);
        w_item[0].eb     = t_vec'(i_second_extents[3*CW-1:0]);
        w_item[0].axb[0] = t_vec'(i_second_axis_x[3*CW-1:0]);
        w_item[0].axb[1] = t_vec'(i_second_axis_y[3*CW-1:0]);
        w_item[0].axb[2] = t_vec'(i_second_axis_z[3*CW-1:0]);
    end

    assign w_v[0]   = i_valid;
    assign w_hit[0] = 1'b1;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        localparam int IA = (g < NFACE) ? g : (g < 2 * NFACE) ? 0 : (g - 2 * NFACE) / NFACE;
        localparam int IB = (g < NFACE) ? 0 : (g < 2 * NFACE) ? g - NFACE
                                                : (g - 2 * NFACE) % NFACE;

        assign w_sel[g].kind = (g < NFACE) ? AX_FACE_A : (g < 2 * NFACE) ? AX_FACE_B : AX_CROSS;
        assign w_sel[g].ia   = 2'(IA);
        assign w_sel[g].ib   = 2'(IB);

        obb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_sel   (w_sel[g]),
            .i_valid (w_v[g]),
            .i_item  (w_item[g]),
            .i_hit   (w_hit[g]),
            .o_valid (w_v[g+1]),
            .o_item  (w_item[g+1]),
            .o_hit   (w_hit[g+1])
        );
    end

    assign o_ready           = w_en;
    assign o_valid           = w_v[NCELL];
    assign o_boxes_intersect = w_hit[NCELL];

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while result stalled");

    a_stall_freezes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(w_v[NCELL/2]) && $stable(o_boxes_intersect))
        else $error("cell row moved while stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
